// ----- sv/brpn_pkg.sv -----
// Shared types and constants for the bitwise postfix stack evaluator.
// No dependencies; every other file in the block imports this package.
package brpn_pkg;

  // Number of operand entries held in the cell chain.
  localparam int STACK_DEPTH = 64;
  // Width of the occupancy count, wide enough to hold STACK_DEPTH itself.
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W = 32;

  // Token operation codes.
  typedef enum logic [2:0] {
    OP_LIT = 3'd0,
    OP_VAR = 3'd1,
    OP_AND = 3'd2,
    OP_OR  = 3'd3,
    OP_XOR = 3'd4,
    OP_NOT = 3'd5,
    OP_SHL = 3'd6,
    OP_SHR = 3'd7
  } op_t;

  // Result error codes.
  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_EMPTY = 2'd3
  } err_t;

  // Per-cycle move of one stack cell.
  typedef enum logic [1:0] {
    SH_HOLD = 2'd0,
    SH_DOWN = 2'd1,
    SH_UP   = 2'd2
  } shift_t;

  // Input token.
  typedef struct packed {
    op_t                       operation;
    logic signed [DATA_W-1:0]  literal;
    logic                      last_token;
  } in_item_t;

  // Result of one expression.
  typedef struct packed {
    logic signed [DATA_W-1:0]  value;
    err_t                      error_code;
  } out_item_t;

endpackage

// ----- sv/bitwise_rpn_stack_evaluator.sv -----
// Top level of the bitwise postfix stack evaluator.
// Depends on brpn_pkg, brpn_cell and brpn_alu.
//
// Usage:
//   Tokens arrive on the in_valid/in_ready channel, one per transfer. A token
//   pushes its literal, pushes the configured variable, or applies and, or,
//   xor, not, shift left or arithmetic shift right to the stack top.
//   Write the variable through cfg_we/cfg_wdata only while the block is idle;
//   the block does not enforce this. A token marked last_token produces one
//   result on out_valid/out_ready: the stack top and an error code (underflow,
//   overflow, empty result); the stack and the sticky error are then emptied
//   for the next expression. Throughput is one token per cycle unless a last
//   token waits: every error-free token is a single shift of the cell chain,
//   with the binary operator computed on the two top cells. out_valid is set
//   in the cycle after the transfer of a last token. The result sits in an
//   output register. While it waits, tokens that are not last are still
//   accepted; a last token waits until the register is free or is being taken
//   in the same cycle. Synchronous reset empties the stack, clears the error,
//   the pending result and the variable; no clearing pass is needed.
module bitwise_rpn_stack_evaluator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [brpn_pkg::DATA_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  brpn_pkg::in_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output brpn_pkg::out_item_t         out_item
);
  import brpn_pkg::*;

  logic [DATA_W-1:0] variable_value;
  logic [CNT_W-1:0]  stack_count;
  logic [CNT_W-1:0]  stack_count_next;
  err_t              sticky_error;
  err_t              sticky_error_next;

  logic [DATA_W-1:0] cell_q [STACK_DEPTH];
  logic [DATA_W-1:0] top_in;
  logic [DATA_W-1:0] alu_out;
  logic [DATA_W-1:0] push_val;
  logic [DATA_W-1:0] top_after;
  shift_t            mode_top;
  shift_t            mode_rest;

  logic              accept;
  logic              is_push;
  logic              is_not;
  logic              is_bin;
  logic              full;
  logic              push_ok;
  logic              not_ok;
  logic              bin_ok;
  err_t              tok_err;
  err_t              err_now;
  err_t              final_err;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      variable_value <= '0;
    end else if (cfg_we) begin
      variable_value <= cfg_wdata;
    end
  end

  // A last token needs the output register; other tokens always go through.
  assign in_ready = ~out_valid | out_ready | ~in_item.last_token;
  assign accept   = in_valid & in_ready;

  // Token decode and stack bounds checks.
  assign is_push  = (in_item.operation == OP_LIT) || (in_item.operation == OP_VAR);
  assign is_not   = (in_item.operation == OP_NOT);
  assign is_bin   = ~is_push & ~is_not;
  assign full     = (stack_count == CNT_W'(STACK_DEPTH));
  assign push_ok  = is_push & ~full;
  assign not_ok   = is_not & (stack_count != '0);
  assign bin_ok   = is_bin & (stack_count >= CNT_W'(2));
  assign push_val = (in_item.operation == OP_LIT) ? DATA_W'(in_item.literal)
                                                  : variable_value;

  brpn_alu u_alu (
    .op     (in_item.operation),
    .a      (cell_q[1]),
    .b      (cell_q[0]),
    .result (alu_out)
  );

  // Error of this token alone, then the first-error-wins merge.
  always_comb begin
    tok_err = ERR_OK;
    if (is_push && full) begin
      tok_err = ERR_OVER;
    end else if ((is_not && !not_ok) || (is_bin && !bin_ok)) begin
      tok_err = ERR_UNDER;
    end
  end

  assign err_now = (sticky_error != ERR_OK) ? sticky_error : tok_err;

  // Stack top and count once this token is applied.
  always_comb begin
    stack_count_next = stack_count;
    top_in           = push_val;
    top_after        = cell_q[0];
    if (push_ok) begin
      stack_count_next = stack_count + CNT_W'(1);
      top_in           = push_val;
      top_after        = push_val;
    end else if (bin_ok) begin
      stack_count_next = stack_count - CNT_W'(1);
      top_in           = alu_out;
      top_after        = alu_out;
    end else if (not_ok) begin
      top_in    = ~cell_q[0];
      top_after = ~cell_q[0];
    end
  end

  always_comb begin
    if (err_now != ERR_OK) begin
      final_err = err_now;
    end else if (stack_count_next == '0) begin
      final_err = ERR_EMPTY;
    end else begin
      final_err = ERR_OK;
    end
  end

  assign sticky_error_next = err_now;

  // Shift commands for the top cell and for the rest of the chain.
  always_comb begin
    mode_top  = SH_HOLD;
    mode_rest = SH_HOLD;
    if (accept) begin
      if (push_ok) begin
        mode_top  = SH_DOWN;
        mode_rest = SH_DOWN;
      end else if (bin_ok) begin
        mode_top  = SH_DOWN;
        mode_rest = SH_UP;
      end else if (not_ok) begin
        mode_top  = SH_DOWN;
      end
    end
  end

  // Chain of stack cells; cell 0 is the top of the stack.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] prev_d;
    logic [DATA_W-1:0] next_d;
    shift_t            cell_mode;

    if (i == 0) begin : g_top
      assign prev_d    = top_in;
      assign cell_mode = mode_top;
    end else begin : g_body
      assign prev_d    = cell_q[i-1];
      assign cell_mode = mode_rest;
    end

    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign next_d = '0;
    end else begin : g_link
      assign next_d = cell_q[i+1];
    end

    brpn_cell u_cell (
      .clk       (clk),
      .mode      (cell_mode),
      .from_prev (prev_d),
      .from_next (next_d),
      .data      (cell_q[i])
    );
  end

  // Stack count and sticky error; a last token starts a fresh expression.
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count  <= '0;
      sticky_error <= ERR_OK;
    end else if (accept) begin
      if (in_item.last_token) begin
        stack_count  <= '0;
        sticky_error <= ERR_OK;
      end else begin
        stack_count  <= stack_count_next;
        sticky_error <= sticky_error_next;
      end
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && in_item.last_token) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload; the value reads zero on any error.
  always_ff @(posedge clk) begin
    if (accept && in_item.last_token) begin
      out_item.error_code <= final_err;
      out_item.value      <= (final_err == ERR_OK) ? $signed(top_after) : '0;
    end
  end

endmodule

// ----- sv/brpn_cell.sv -----
// One entry of the operand stack, held in a shift chain of identical cells.
// Depends on brpn_pkg for the shift command type.
module brpn_cell (
  input  logic                        clk,
  input  brpn_pkg::shift_t            mode,
  input  logic [brpn_pkg::DATA_W-1:0] from_prev,
  input  logic [brpn_pkg::DATA_W-1:0] from_next,
  output logic [brpn_pkg::DATA_W-1:0] data
);
  import brpn_pkg::*;

  // A push moves entries away from the top; a pop pulls them toward it.
  always_ff @(posedge clk) begin
    case (mode)
      SH_DOWN: data <= from_prev;
      SH_UP:   data <= from_next;
      default: data <= data;
    endcase
  end

endmodule

// ----- sv/brpn_alu.sv -----
// Bitwise binary operator unit working on the two top stack entries.
// Depends on brpn_pkg for the operation codes.
module brpn_alu (
  input  brpn_pkg::op_t               op,
  input  logic [brpn_pkg::DATA_W-1:0] a,
  input  logic [brpn_pkg::DATA_W-1:0] b,
  output logic [brpn_pkg::DATA_W-1:0] result
);
  import brpn_pkg::*;

  localparam int SH_W = $clog2(DATA_W);

  logic                     big_shift;
  logic [SH_W-1:0]          amount;
  logic [DATA_W-1:0]        shl_val;
  logic signed [DATA_W-1:0] sra_val;
  logic [DATA_W-1:0]        shr_val;

  // Any amount of DATA_W or more counts as a full shift.
  assign big_shift = |b[DATA_W-1:SH_W];
  assign amount    = b[SH_W-1:0];

  // The arithmetic shift is kept in a signed signal of its own so the sign fill survives.
  assign sra_val = $signed(a) >>> amount;

  assign shl_val = big_shift ? '0 : (a << amount);
  assign shr_val = big_shift ? {DATA_W{a[DATA_W-1]}} : sra_val;

  // Select the operator result.
  always_comb begin
    case (op)
      OP_AND:  result = a & b;
      OP_OR:   result = a | b;
      OP_XOR:  result = a ^ b;
      OP_SHL:  result = shl_val;
      OP_SHR:  result = shr_val;
      default: result = a;
    endcase
  end

endmodule

// ----- sv/brpn_chk.sv -----
// Port-level checker for the bitwise postfix stack evaluator, with its bind.
// Depends on brpn_pkg and the bitwise_rpn_stack_evaluator ports.
module brpn_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input brpn_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_ready,
  input brpn_pkg::out_item_t out_item
);
  import brpn_pkg::*;

  logic last_xfer;
  assign last_xfer = in_valid & in_ready & in_item.last_token;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Reset leaves no pending result.
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // Any error code forces a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.error_code != ERR_OK |-> out_item.value == '0)
    else $error("nonzero value with error");

  // The transfer of a last token shows a result in the next cycle.
  a_last_result: assert property (@(posedge clk) disable iff (rst)
    last_xfer |=> out_valid)
    else $error("last token without result");

  // A literal pushed as the last token is the reported top unless in error.
  a_last_lit: assert property (@(posedge clk) disable iff (rst)
    last_xfer && in_item.operation == OP_LIT |=>
      out_item.value == $past(in_item.literal) || out_item.error_code != ERR_OK)
    else $error("last literal not reported");

endmodule

bind bitwise_rpn_stack_evaluator brpn_chk u_brpn_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
